### rtl/u8d_pkg.sv
`default_nettype none

package u8d_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RESERVED  = 2'd1,
    STATUS_MALFORMED = 2'd2
  } status_t;

  localparam logic [7:0]  MASK_FIRST_BIT = 8'h80;
  localparam logic [7:0]  MASK_LOW6      = 8'h3F;
  localparam logic [15:0] UNIT_MAX       = 16'hFFFF;
  localparam logic [15:0] UNIT_NONCHAR   = 16'hFFFE;

  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // One step's outcome, handed from the decode step to the result register
  typedef struct packed {
    logic        emit;
    logic [15:0] code_unit;
    logic [2:0]  seq_length;
    status_t     status;
  } result_t;

endpackage

`default_nettype wire

### rtl/utf8_stream_decoder_16bit.sv
// UTF-8 byte stream to 16-bit code unit decoder.
// Input channel: in_valid / in_ready with one byte per transaction on
// in_data_byte. Output channel: out_valid / out_ready with one code unit,
// its byte count and a status per transaction. Multi-byte characters give
// one output transaction for the last byte of the sequence only; lead and
// middle bytes give none. Status 1 flags a multi-byte result of 0, 0xFFFE
// or 0xFFFF; status 2 flags a stray continuation byte or a byte of 0xF8 and
// above. Four-byte characters keep only the low 16 bits.
// Path: the byte completing a result sits in the input register, and the
// result register then loads the result once it is free to take it.
// Throughput: one byte per cycle while the receiver does not stall.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to the idle state, with no partial sequence held.
// When the receiver stalls, the result register holds its transaction; the
// input register keeps taking bytes that produce no result, and back
// pressure reaches in_ready only once a second result is waiting.
`default_nettype none

module utf8_stream_decoder_16bit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_data_byte,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_code_unit,
  output      logic [2:0]  out_seq_length,
  output      logic [1:0]  out_status
);

  logic              in_valid_r;
  logic [7:0]        in_data_r;
  logic              out_valid_r;
  logic [15:0]       code_unit_r;
  logic [2:0]        seq_length_r;
  u8d_pkg::status_t  status_r;
  u8d_pkg::result_t  res;
  logic              out_free;
  logic              step_fire;

  // Result register can take a new transaction when empty or being drained
  assign out_free  = !out_valid_r || out_ready;
  // Advance the decode step unless its result has nowhere to go
  assign step_fire = in_valid_r && (!res.emit || out_free);
  assign in_ready  = !in_valid_r || step_fire;

  u8d_step u_step (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (step_fire),
    .data_byte (in_data_r),
    .res       (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data_byte;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire && res.emit) begin
      code_unit_r  <= res.code_unit;
      seq_length_r <= res.seq_length;
      status_r     <= res.status;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_unit  = code_unit_r;
  assign out_seq_length = seq_length_r;
  assign out_status     = status_r;

  // A held byte that could not advance is still held next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step_fire |=> in_valid_r)
    else $error("input register dropped a stalled byte");

  // Every result carries a byte count of one to four
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_seq_length != 3'd0 && out_seq_length <= u8d_pkg::LEN_FOUR))
    else $error("result byte count out of range");

  // A malformed byte is reported alone with a zero code unit
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == u8d_pkg::STATUS_MALFORMED |->
      out_code_unit == 16'h0000 && out_seq_length == u8d_pkg::LEN_ONE)
    else $error("malformed result carries data");

  // The reserved flag only ever marks multi-byte results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == u8d_pkg::STATUS_RESERVED |->
      out_seq_length != u8d_pkg::LEN_ONE)
    else $error("single-byte result flagged as reserved");

endmodule

`default_nettype wire

### rtl/u8d_step.sv
`default_nettype none

module u8d_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [7:0]        data_byte,
  output u8d_pkg::result_t       res
);

  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [2:0]  exp_len_r, exp_len_nxt;
  logic [15:0] shifted;

  assign shifted = {acc_r[9:0], data_byte[5:0] & u8d_pkg::MASK_LOW6[5:0]};

  always_comb begin
    acc_nxt        = acc_r;
    rem_nxt        = rem_r;
    exp_len_nxt    = exp_len_r;
    res.emit       = 1'b0;
    res.code_unit  = 16'h0000;
    res.seq_length = u8d_pkg::LEN_ONE;
    res.status     = u8d_pkg::STATUS_OK;
    if (rem_r == 2'd0) begin
      if ((data_byte & u8d_pkg::MASK_FIRST_BIT) == 8'h00) begin
        res.emit      = 1'b1;
        res.code_unit = {8'h00, data_byte};
      end else if (data_byte inside {[8'hC0:8'hDF]}) begin
        acc_nxt     = {11'h000, data_byte[4:0]};
        exp_len_nxt = u8d_pkg::LEN_TWO;
        rem_nxt     = 2'd1;
      end else if (data_byte inside {[8'hE0:8'hEF]}) begin
        acc_nxt     = {12'h000, data_byte[3:0]};
        exp_len_nxt = u8d_pkg::LEN_THREE;
        rem_nxt     = 2'd2;
      end else if (data_byte inside {[8'hF0:8'hF7]}) begin
        acc_nxt     = {13'h0000, data_byte[2:0]};
        exp_len_nxt = u8d_pkg::LEN_FOUR;
        rem_nxt     = 2'd3;
      end else begin
        // stray continuation byte or invalid lead byte
        res.emit   = 1'b1;
        res.status = u8d_pkg::STATUS_MALFORMED;
      end
    end else begin
      rem_nxt = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        res.emit       = 1'b1;
        res.code_unit  = shifted;
        res.seq_length = exp_len_r;
        if (shifted == 16'h0000 || shifted == u8d_pkg::UNIT_NONCHAR ||
            shifted == u8d_pkg::UNIT_MAX) begin
          res.status = u8d_pkg::STATUS_RESERVED;
        end
        acc_nxt     = 16'h0000;
        exp_len_nxt = 3'd0;
      end else begin
        acc_nxt = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= 16'h0000;
      rem_r     <= 2'd0;
      exp_len_r <= 3'd0;
    end else if (fire) begin
      acc_r     <= acc_nxt;
      rem_r     <= rem_nxt;
      exp_len_r <= exp_len_nxt;
    end
  end

endmodule

`default_nettype wire

### bench/tb_utf8_stream_decoder_16bit.sv
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_16bit;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          RANDOM_BYTES = 1600;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [7:0]  LOW7_MASK    = 8'h7F;
  localparam logic [7:0]  CONT_MARK    = 8'h80;

  // One byte waiting to go out; hold makes the sender wait for all results first
  typedef struct packed {
    logic       hold;
    logic [7:0] data;
  } feed_t;

  // One decoded character as the decoder should report it
  typedef struct {
    logic [15:0]      code_unit;
    logic [2:0]       seq_length;
    u8d_pkg::status_t status;
  } char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_code_unit;
  logic [2:0]  out_seq_length;
  logic [1:0]  out_status;

  feed_t stream_q[$];
  char_t char_q[$];

  // Decoder state as the predictor tracks it
  logic [15:0] dec_acc = '0;
  logic [1:0]  dec_left = '0;
  logic [2:0]  dec_len = '0;

  logic byte_taken = 1'b0;
  logic char_taken = 1'b0;
  int   bytes_accepted = 0;
  int   byte_total = -1;
  int   fail_count = 0;
  int   cycle_count = 0;
  int   send_gap = 0;
  int   send_steady = 0;
  int   recv_stall = 0;
  int   recv_steady = 0;

  utf8_stream_decoder_16bit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_unit  (out_code_unit),
    .out_seq_length (out_seq_length),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  // Pick an idle gap: mostly none or short, a few long, and every so often
  // a stretch of back-to-back cycles with no idling at all.
  task automatic next_gap(inout int steady, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (steady > 0) begin
      steady--;
      gap = 0;
    end else if (r < 3) begin
      steady = $urandom_range(20, 80);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 92) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
  endtask

  // Advance the predicted decoder by one accepted byte; queue the character
  // it completes, if any.
  task automatic decode_byte(input logic [7:0] b);
    int    ones;
    char_t c;
    if (dec_left == 2'd0) begin
      ones = 0;
      while (ones < 8 && b[7 - ones]) ones++;
      if ((b & u8d_pkg::MASK_FIRST_BIT) == 8'h00) begin
        c.code_unit  = {8'h00, b};
        c.seq_length = u8d_pkg::LEN_ONE;
        c.status     = u8d_pkg::STATUS_OK;
        char_q.push_back(c);
      end else if (ones < 2 || ones > 4) begin
        // stray continuation byte or a lead byte of 0xF8 and above
        c.code_unit  = 16'h0000;
        c.seq_length = u8d_pkg::LEN_ONE;
        c.status     = u8d_pkg::STATUS_MALFORMED;
        char_q.push_back(c);
      end else begin
        dec_acc  = {8'h00, b & (LOW7_MASK >> ones)};
        dec_len  = 3'(ones);
        dec_left = 2'(ones - 1);
      end
    end else begin
      // any byte inside a sequence counts as a continuation: keep 6 bits
      dec_acc  = {dec_acc[9:0], b[5:0] & u8d_pkg::MASK_LOW6[5:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left == 2'd0) begin
        c.code_unit  = dec_acc;
        c.seq_length = dec_len;
        if (dec_acc == 16'h0000 || dec_acc == u8d_pkg::UNIT_NONCHAR ||
            dec_acc == u8d_pkg::UNIT_MAX)
          c.status = u8d_pkg::STATUS_RESERVED;
        else
          c.status = u8d_pkg::STATUS_OK;
        char_q.push_back(c);
        dec_acc = '0;
        dec_len = '0;
      end
    end
  endtask

  // Monitor: check results first so a result never matches a character
  // predicted at the same edge, then predict from the accepted byte.
  always @(posedge clk) begin
    char_t c;
    byte_taken <= rst_n && in_valid && in_ready;
    char_taken <= rst_n && out_valid && out_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (char_q.size() == 0) begin
          $error("unexpected transaction: code_unit=%h seq_length=%0d status=%0d",
                 out_code_unit, out_seq_length, out_status);
          fail_count++;
        end else begin
          c = char_q.pop_front();
          if (out_code_unit !== c.code_unit) begin
            $error("code_unit: expected %h, got %h", c.code_unit, out_code_unit);
            fail_count++;
          end
          if (out_seq_length !== c.seq_length) begin
            $error("seq_length: expected %0d, got %0d", c.seq_length, out_seq_length);
            fail_count++;
          end
          if (out_status !== c.status) begin
            $error("status: expected %0d, got %0d", c.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(in_data_byte);
        bytes_accepted++;
      end
    end
  end

  // Driver: move to the next byte only once the current one is taken; hold
  // valid and data steady otherwise.
  always @(negedge clk) begin
    feed_t f;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0 && stream_q[0].hold && char_q.size() != 0) begin
        // drain every outstanding result before this byte goes out
        in_valid <= 1'b0;
      end else if (stream_q.size() != 0) begin
        f = stream_q.pop_front();
        in_valid     <= 1'b1;
        in_data_byte <= f.data;
        next_gap(send_steady, send_gap);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall for a random gap after each result transaction.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (char_taken) next_gap(recv_steady, recv_stall);
    end
  end

  // Watchdog: end the run with an error once the cycle limit is reached.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic hold = 1'b0);
    feed_t f;
    f.hold = hold;
    f.data = b;
    stream_q.push_back(f);
  endtask

  // Queue a lead byte for a len-byte sequence and then ncont continuations.
  task automatic push_seq(input int len, input int ncont, input logic hold);
    logic [7:0] lead;
    lead = 8'($urandom_range(0, 255));
    case (len)
      2:       lead = {3'b110, lead[4:0]};
      3:       lead = {4'b1110, lead[3:0]};
      4:       lead = {5'b11110, lead[2:0]};
      default: lead = {1'b0, lead[6:0]};
    endcase
    push_byte(lead, hold);
    repeat (ncont) push_byte(CONT_MARK | 8'($urandom_range(0, 63)));
  endtask

  // Queue a sequence that decodes to a null or reserved code unit.
  task automatic push_reserved(input logic hold);
    case ($urandom_range(0, 5))
      0: begin push_byte(8'hC0, hold); push_byte(8'h80); end
      1: begin push_byte(8'hE0, hold); push_byte(8'h80); push_byte(8'h80); end
      2: begin push_byte(8'hEF, hold); push_byte(8'hBF); push_byte(8'hBE); end
      3: begin push_byte(8'hEF, hold); push_byte(8'hBF); push_byte(8'hBF); end
      4: begin
        push_byte(8'hF0, hold); push_byte(8'h8F); push_byte(8'hBF); push_byte(8'hBF);
      end
      default: begin
        push_byte(8'hF4, hold); push_byte(8'h80); push_byte(8'h80); push_byte(8'h80);
      end
    endcase
  endtask

  initial begin
    int   r;
    int   len;
    logic hold;

    // Directed: ASCII extremes including null, stray continuations, invalid
    // leads, one sequence of each length (four-byte truncated), reserved
    // and null results, and a lead byte arriving mid-sequence.
    push_byte(8'h00); push_byte(8'h7F);
    push_byte(8'h80); push_byte(8'hBF);
    push_byte(8'hF8); push_byte(8'hFF);
    push_byte(8'hC2); push_byte(8'hA9);
    push_byte(8'hE2); push_byte(8'h82); push_byte(8'hAC);
    push_byte(8'hF0); push_byte(8'h9F); push_byte(8'h98); push_byte(8'h80);
    push_byte(8'hC0); push_byte(8'h80);
    push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBE);
    push_byte(8'hEF); push_byte(8'hBF); push_byte(8'hBF);
    push_byte(8'hE0); push_byte(8'hC3); push_byte(8'hFF);

    // Random: mostly well-formed sequences, some reserved results, truncated
    // sequences and raw noise bytes. Drain fully at the start and now and then.
    hold = 1'b1;
    while (stream_q.size() < 26 + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        len = $urandom_range(1, 4);
        push_seq(len, len - 1, hold);
      end else if (r < 76) begin
        push_reserved(hold);
      end else if (r < 86) begin
        len = $urandom_range(2, 4);
        push_seq(len, $urandom_range(0, len - 2), hold);
      end else begin
        push_byte(8'($urandom_range(0, 255)), hold);
      end
      hold = ($urandom_range(0, 199) == 0);
    end
    byte_total = stream_q.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every byte to be taken and every result to arrive, then let
    // the pipeline settle so a late extra result is still caught.
    while (bytes_accepted < byte_total || char_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

### utf8_stream_decoder_16bit.f
rtl/u8d_pkg.sv
rtl/u8d_step.sv
rtl/utf8_stream_decoder_16bit.sv
bench/tb_utf8_stream_decoder_16bit.sv
